### rtl/core/lmcb_pkg.sv
// Package: shared types, register indexes and arithmetic constants of the LED mask blender.
package lmcb_pkg;

	typedef enum logic [1:0] {
		FM_INSTANT = 2'd0,
		FM_LINEAR  = 2'd1,
		FM_QUAD    = 2'd2,
		FM_DEEP    = 2'd3
	} fade_mode_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FADE_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_TIME  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd2;

	localparam fade_mode_t  RST_FADE_MODE  = FM_LINEAR;
	localparam logic [15:0] RST_FADE_TIME  = 16'd250;
	localparam logic [8:0]  RST_BRIGHTNESS = 9'd256;

	// Fade position in Q1.8, 256 is a finished transition
	localparam logic [8:0] FULL_POS      = 9'd256;
	localparam logic [8:0] DONE_POS      = 9'd254;
	localparam logic [8:0] DEEP_OUT_LAST = 9'd115;
	localparam logic [8:0] DEEP_IN_FIRST = 9'd141;

	localparam logic [15:0] MASK_FULL = 16'd65280;
	localparam int DIV_STEPS = 9;

	// Reciprocals for floor division by 5, 25 and 255 over the value ranges in use
	localparam logic [19:0] RECIP5    = 20'd838861;
	localparam int          RECIP5_SH = 22;
	localparam logic [21:0] RECIP25    = 22'd2684355;
	localparam int          RECIP25_SH = 26;
	localparam logic [16:0] RECIP255    = 17'd65794;
	localparam int          RECIP255_SH = 24;

	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		fade_mode_t mode;
		logic       pre_done;
		logic [7:0] mask_from;
		logic [7:0] mask_to;
		rgb_t       on_c;
		rgb_t       off_c;
	} led_ctx_t;

	typedef struct packed {
		led_ctx_t    ctx;
		logic [32:0] rem;
		logic [31:0] den;
		logic [8:0]  quo;
	} div_stage_t;

	typedef struct packed {
		rgb_t        on_c;
		rgb_t        off_c;
		logic [7:0]  mask_to;
		logic        done;
		logic        deep_out;
		logic        deep_in;
		logic        keep_out;
		logic        keep_in;
		logic [16:0] lin;
		logic [18:0] out_prod;
		logic [20:0] in_prod;
	} mask_stage_t;

	typedef struct packed {
		rgb_t        on_c;
		rgb_t        off_c;
		logic        done;
		logic [15:0] mask;
	} mix_stage_t;

endpackage

### rtl/core/lmcb_if.sv
// Interfaces: LED item channel into the blender and drive value channel out of it.
interface lmcb_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] elapsed_ms;
	logic [7:0]  mask_from;
	logic [7:0]  mask_to;
	logic [7:0]  on_red;
	logic [7:0]  on_green;
	logic [7:0]  on_blue;
	logic [7:0]  off_red;
	logic [7:0]  off_green;
	logic [7:0]  off_blue;

	modport source (output valid, elapsed_ms, mask_from, mask_to, on_red, on_green, on_blue,
		off_red, off_green, off_blue, input ready);
	modport sink (input valid, elapsed_ms, mask_from, mask_to, on_red, on_green, on_blue,
		off_red, off_green, off_blue, output ready);
endinterface

interface lmcb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       fade_done;

	modport source (output valid, out_red, out_green, out_blue, fade_done, input ready);
	modport sink (input valid, out_red, out_green, out_blue, fade_done, output ready);
endinterface

### rtl/core/led_mask_crossfade_blender_unit.sv
// Top level: pipelined per-LED mask crossfade and colour blender.
//
// Usage: feed one LED item per cycle on mask_item (valid/ready); each item
// yields exactly one drive value item on drive_item, in order.
// Configuration (fade mode, fade time, brightness) is written through cfg_we/cfg_index/
// cfg_data, by the user only while the pipeline is empty (the block does not enforce it); index 3 is ignored.
//
// Throughput: one item per cycle, sustained while drive_item.ready stays high. There
// are 15 register stages: the operand stage, the fade position divider with one
// quotient bit per stage over nine stages, two mask shaping stages and three
// colour stages.
//
// Reset: arst_n clears all stage valid bits and loads the register defaults
// (linear crossfade, 250 ms, full brightness).
// Stall: each stage advances when it is empty or the stage after it advances,
// so bubbles collapse while drive_item.ready is low and mask_item.ready stays
// high until every stage holds an item. Nothing is dropped or repeated.
module led_mask_crossfade_blender_unit import lmcb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lmcb_in_if.sink               mask_item,
	lmcb_out_if.source            drive_item
);

	// Stage map: div_s[0] is s1, div_s[1..9] are s2..s10, then s11..s15
	localparam int ST_MASK  = DIV_STEPS + 1;
	localparam int ST_SEL   = DIV_STEPS + 2;
	localparam int ST_SUM   = DIV_STEPS + 3;
	localparam int ST_SCL   = DIV_STEPS + 4;
	localparam int ST_OUT   = DIV_STEPS + 5;
	localparam int STAGES   = DIV_STEPS + 6;

	fade_mode_t  fade_mode_q;
	logic [15:0] fade_time_q;
	logic [8:0]  brightness_q;

	logic [STAGES-1:0] stage_vld_q;
	logic [STAGES:0]   adv;

	div_stage_t  div_s [DIV_STEPS+1];
	mask_stage_t m_s11;
	mix_stage_t  m_s12;
	logic [2:0][23:0] sum_s13;
	logic        done_s13;
	logic [2:0][16:0] scl_s14;
	logic        done_s14;
	rgb_t        out_s15;
	logic        done_s15;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_mode_q  <= RST_FADE_MODE;
			fade_time_q  <= RST_FADE_TIME;
			brightness_q <= RST_BRIGHTNESS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FADE_MODE:  fade_mode_q  <= fade_mode_t'(cfg_data[1:0]);
				REG_FADE_TIME:  fade_time_q  <= cfg_data;
				REG_BRIGHTNESS: brightness_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Stage k advances when it or any later stage is empty, or the sink takes the output
	assign adv[STAGES] = drive_item.ready;
	for (genvar k = 0; k < STAGES; k++) begin : g_adv
		assign adv[k] = drive_item.ready || !(&stage_vld_q[STAGES-1:k]);
	end

	assign mask_item.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (adv[0]) stage_vld_q[0] <= mask_item.valid;
			for (int k = 1; k < STAGES; k++) begin
				if (adv[k]) stage_vld_q[k] <= stage_vld_q[k-1];
			end
		end
	end

	// s1: squares for the quadratic mode, select dividend and divisor
	logic [31:0] e_sq;
	logic [31:0] t_sq;
	div_stage_t  div_in;

	assign e_sq = 32'(mask_item.elapsed_ms) * 32'(mask_item.elapsed_ms);
	assign t_sq = 32'(fade_time_q) * 32'(fade_time_q);

	always_comb begin
		div_in.ctx.mode      = fade_mode_q;
		div_in.ctx.pre_done  = (fade_mode_q == FM_INSTANT) || (fade_time_q == '0) ||
			(mask_item.elapsed_ms > fade_time_q);
		div_in.ctx.mask_from = mask_item.mask_from;
		div_in.ctx.mask_to   = mask_item.mask_to;
		div_in.ctx.on_c      = {mask_item.on_blue, mask_item.on_green, mask_item.on_red};
		div_in.ctx.off_c     = {mask_item.off_blue, mask_item.off_green, mask_item.off_red};
		div_in.quo           = '0;
		if (fade_mode_q == FM_QUAD) begin
			div_in.rem = {1'b0, e_sq};
			div_in.den = t_sq;
		end else begin
			div_in.rem = 33'(mask_item.elapsed_ms);
			div_in.den = 32'(fade_time_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) div_s[0] <= div_in;
	end

	// s2..s10: restoring division, one quotient bit per stage, MSB (the 256 bit) first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [32:0] trial;
		logic        take;
		div_stage_t  nxt;

		if (k == 0) begin : g_first
			assign trial = div_s[k].rem;
		end else begin : g_shift
			assign trial = {div_s[k].rem[31:0], 1'b0};
		end

		assign take = trial >= {1'b0, div_s[k].den};

		always_comb begin
			nxt     = div_s[k];
			nxt.rem = take ? trial - {1'b0, div_s[k].den} : trial;
			nxt.quo = {div_s[k].quo[7:0], take};
		end

		always_ff @(posedge clk) begin
			if (adv[k+1]) div_s[k+1] <= nxt;
		end
	end

	// s11: fade position, linear mask mix and the deep fade products
	led_ctx_t    ctx_d;
	logic [8:0]  quo_d;
	logic        done_d;
	logic [8:0]  pos_d;
	logic [11:0] pos11_d;
	logic [10:0] out_k_d;
	logic [9:0]  in_k_d;
	mask_stage_t mask_d;

	assign ctx_d   = div_s[DIV_STEPS].ctx;
	assign quo_d   = div_s[DIV_STEPS].quo;
	assign done_d  = ctx_d.pre_done || (quo_d >= DONE_POS);
	assign pos_d   = done_d ? FULL_POS : quo_d;
	assign pos11_d = 12'(pos_d) * 12'd11;
	// Only used where the position keeps these terms positive
	assign out_k_d = 11'(12'd1280 - pos11_d);
	assign in_k_d  = 10'(12'(pos_d) * 12'd5 - 12'd704);

	always_comb begin
		mask_d.on_c     = ctx_d.on_c;
		mask_d.off_c    = ctx_d.off_c;
		mask_d.mask_to  = ctx_d.mask_to;
		mask_d.done     = done_d;
		mask_d.deep_out = (ctx_d.mode == FM_DEEP) && (ctx_d.mask_from != '0) &&
			(ctx_d.mask_to == '0);
		mask_d.deep_in  = (ctx_d.mode == FM_DEEP) && (ctx_d.mask_to != '0) &&
			(ctx_d.mask_from == '0);
		mask_d.keep_out = pos_d <= DEEP_OUT_LAST;
		mask_d.keep_in  = pos_d >= DEEP_IN_FIRST;
		mask_d.lin      = 17'(ctx_d.mask_from) * 17'(9'(FULL_POS - pos_d)) +
			17'(ctx_d.mask_to) * 17'(pos_d);
		mask_d.out_prod = 19'(ctx_d.mask_from) * 19'(out_k_d);
		mask_d.in_prod  = 21'(ctx_d.mask_to) * 21'(in_k_d) * 21'd11;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_MASK]) m_s11 <= mask_d;
	end

	// s12: divide the deep fade products by constants, pick the mask, clamp
	logic [38:0] out_div;
	logic [42:0] in_div;
	logic [16:0] mask_raw;
	mix_stage_t  mix_d;

	assign out_div = 39'(m_s11.out_prod) * 39'(RECIP5);
	assign in_div  = 43'(m_s11.in_prod) * 43'(RECIP25);

	always_comb begin
		if (m_s11.done) begin
			mask_raw = {1'b0, m_s11.mask_to, 8'h00};
		end else if (m_s11.deep_in) begin
			mask_raw = m_s11.keep_in ? in_div[RECIP25_SH +: 17] : '0;
		end else if (m_s11.deep_out) begin
			mask_raw = m_s11.keep_out ? out_div[RECIP5_SH +: 17] : '0;
		end else begin
			mask_raw = m_s11.lin;
		end
		mix_d.on_c  = m_s11.on_c;
		mix_d.off_c = m_s11.off_c;
		mix_d.done  = m_s11.done;
		mix_d.mask  = (mask_raw > 17'(MASK_FULL)) ? MASK_FULL : mask_raw[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv[ST_SEL]) m_s12 <= mix_d;
	end

	// s13: foreground over background per channel
	logic [2:0][23:0] sum_d;
	logic [15:0]      inv_mask;

	assign inv_mask = MASK_FULL - m_s12.mask;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_d[c] = 24'(m_s12.on_c[c]) * 24'(m_s12.mask) +
				24'(m_s12.off_c[c]) * 24'(inv_mask);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_SUM]) begin
			sum_s13  <= sum_d;
			done_s13 <= m_s12.done;
		end
	end

	// s14: brightness scale, keep the sum divided by 65536
	logic [8:0]       bright;
	logic [2:0][32:0] scl_full;
	logic [2:0][16:0] scl_d;

	assign bright = brightness_q[8] ? FULL_POS : brightness_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			scl_full[c] = 33'(sum_s13[c]) * 33'(bright);
			scl_d[c]    = scl_full[c][32:16];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_SCL]) begin
			scl_s14  <= scl_d;
			done_s14 <= done_s13;
		end
	end

	// s15: divide by 255 and saturate
	logic [2:0][33:0] chan_full;
	logic [2:0][9:0]  chan_q;
	rgb_t             chan_d;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			chan_full[c] = 34'(scl_s14[c]) * 34'(RECIP255);
			chan_q[c]    = chan_full[c][RECIP255_SH +: 10];
			chan_d[c]    = (chan_q[c] > 10'd255) ? 8'hFF : chan_q[c][7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			out_s15  <= chan_d;
			done_s15 <= done_s14;
		end
	end

	assign drive_item.valid     = stage_vld_q[STAGES-1];
	assign drive_item.out_red   = out_s15[0];
	assign drive_item.out_green = out_s15[1];
	assign drive_item.out_blue  = out_s15[2];
	assign drive_item.fade_done = done_s15;

endmodule

### rtl/core/lmcb_checker.sv
// Checker: port-level properties of the blender, bound to the top level.
module lmcb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic       fade_done
);

	// Hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green) &&
		$stable(out_blue) && $stable(fade_done))
		else $error("stalled result changed");

	// An empty output stage means the pipeline can take an item
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	// A draining sink never stalls the source
	a_flow_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while sink takes results");

	// Drop all results while in reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result shown during reset");

endmodule

bind led_mask_crossfade_blender_unit lmcb_checker u_lmcb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (mask_item.ready),
	.out_valid (drive_item.valid),
	.out_ready (drive_item.ready),
	.out_red   (drive_item.out_red),
	.out_green (drive_item.out_green),
	.out_blue  (drive_item.out_blue),
	.fade_done (drive_item.fade_done)
);

### tb/sv/tb_led_mask_crossfade_blender_unit.sv
// Testbench: LED mask crossfade blender against a bit-exact predictor, directed and random items.
module tb_led_mask_crossfade_blender_unit;
	import lmcb_pkg::*;

	// Pipeline latency, plus some slack before register writes
	localparam int PIPE_LAT = 14;
	localparam int SETTLE   = PIPE_LAT + 8;

	// The unused register slot: writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int RAND_PHASES    = 10;
	localparam int ITEMS_PER_PHASE = 175;

	// One LED item as it travels on mask_item; packed so directed items read as one concatenation
	typedef struct packed {
		logic [15:0] elapsed_ms;
		logic [7:0]  mask_from;
		logic [7:0]  mask_to;
		logic [7:0]  on_red;
		logic [7:0]  on_green;
		logic [7:0]  on_blue;
		logic [7:0]  off_red;
		logic [7:0]  off_green;
		logic [7:0]  off_blue;
	} led_item_t;

	// One drive value item as it leaves on drive_item
	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       fade_done;
	} drive_t;

	// Mirrors the three registers, predicts the drive value of each accepted LED item and
	// compares the block's output against the oldest prediction.
	class blend_scoreboard;
		fade_mode_t  mode;
		logic [15:0] fade_time;
		logic [8:0]  bright;
		drive_t      expected_drive[$];
		int          fails;

		function new();
			mode      = RST_FADE_MODE;
			fade_time = RST_FADE_TIME;
			bright    = RST_BRIGHTNESS;
			fails     = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FADE_MODE:  mode = fade_mode_t'(data[1:0]);
				REG_FADE_TIME:  fade_time = data;
				REG_BRIGHTNESS: bright = data[8:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] scale_channel(longint unsigned fg, longint unsigned bg,
				longint unsigned lvl, longint unsigned gain);
			longint unsigned acc;
			acc = ((fg * lvl + bg * (MASK_FULL - lvl)) * gain) / 64'd16711680;
			return (acc > 255) ? 8'd255 : acc[7:0];
		endfunction

		function drive_t blend_led(led_item_t it);
			longint unsigned e, span, gain, pos, lvl, src, dst;
			bit fin;
			drive_t d;
			e    = it.elapsed_ms;
			span = fade_time;
			gain = (bright > 9'd256) ? 256 : bright;
			src  = it.mask_from;
			dst  = it.mask_to;
			pos  = FULL_POS;
			fin  = 0;
			if (mode == FM_INSTANT || span == 0 || e > span) begin
				fin = 1;
			end else begin
				if (mode == FM_QUAD)
					pos = (e * e * 256) / (span * span);
				else
					pos = (e * 256) / span;
				if (pos > FULL_POS) pos = FULL_POS;
				if (pos >= DONE_POS) fin = 1;
			end
			if (fin) pos = FULL_POS;
			lvl = src * (FULL_POS - pos) + dst * pos;
			// Deep fade: darken the outgoing LEDs first, light the incoming ones late
			if (mode == FM_DEEP) begin
				if (src > 0 && dst == 0)
					lvl = (pos <= DEEP_OUT_LAST) ? (src * (1280 - 11 * pos)) / 5 : 0;
				if (dst > 0 && src == 0)
					lvl = (pos >= DEEP_IN_FIRST) ? (dst * 11 * (5 * pos - 704)) / 25 : 0;
			end
			if (fin) lvl = dst * 256;
			if (lvl > MASK_FULL) lvl = MASK_FULL;
			d.out_red   = scale_channel(it.on_red, it.off_red, lvl, gain);
			d.out_green = scale_channel(it.on_green, it.off_green, lvl, gain);
			d.out_blue  = scale_channel(it.on_blue, it.off_blue, lvl, gain);
			d.fade_done = fin;
			return d;
		endfunction

		function void note_item(led_item_t it);
			expected_drive.push_back(blend_led(it));
		endfunction

		function void check_drive(drive_t got);
			drive_t want;
			if (expected_drive.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("%0t: drive item with nothing expected: r=%0d g=%0d b=%0d done=%0b",
						$realtime, got.out_red, got.out_green, got.out_blue, got.fade_done);
				return;
			end
			want = expected_drive.pop_front();
			if (got !== want) begin
				fails++;
				if (fails <= 10)
					$display("%0t: drive mismatch exp r=%0d g=%0d b=%0d done=%0b,",
						$realtime, want.out_red, want.out_green, want.out_blue, want.fade_done,
						" got r=%0d g=%0d b=%0d done=%0b",
						got.out_red, got.out_green, got.out_blue, got.fade_done);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lmcb_in_if  mask_item();
	lmcb_out_if drive_item();

	blend_scoreboard sb = new();

	// Sender burst bookkeeping and receiver stall pattern state
	int burst_left;
	int stall_regime;
	int regime_left;
	int regime_tick;

	led_mask_crossfade_blender_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mask_item  (mask_item),
		.drive_item (drive_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop far beyond the slowest legal run
	initial begin
		#3000000;
		$display("tb_led_mask_crossfade_blender_unit: errors");
		$finish;
	end

	// Receiver: check every accepted drive item, then pick the next ready value.
	// Regimes change at random: always ready, mostly ready, mostly stalled, and a fixed on/off comb.
	always @(posedge clk) begin
		if (!arst_n) begin
			drive_item.ready <= 1'b0;
			stall_regime <= 0;
			regime_left  <= 0;
			regime_tick  <= 0;
		end else begin
			if (drive_item.valid && drive_item.ready)
				sb.check_drive({drive_item.out_red, drive_item.out_green,
					drive_item.out_blue, drive_item.fade_done});
			if (regime_left == 0) begin
				stall_regime <= $urandom_range(0, 3);
				regime_left  <= $urandom_range(20, 300);
			end else begin
				regime_left <= regime_left - 1;
			end
			regime_tick <= regime_tick + 1;
			case (stall_regime)
				0: drive_item.ready <= 1'b1;
				1: drive_item.ready <= ($urandom_range(0, 3) != 0);
				2: drive_item.ready <= ($urandom_range(0, 3) == 0);
				default: drive_item.ready <= ((regime_tick % 5) < 3);
			endcase
		end
	end

	task automatic load_item(input led_item_t it);
		mask_item.elapsed_ms <= it.elapsed_ms;
		mask_item.mask_from  <= it.mask_from;
		mask_item.mask_to    <= it.mask_to;
		mask_item.on_red     <= it.on_red;
		mask_item.on_green   <= it.on_green;
		mask_item.on_blue    <= it.on_blue;
		mask_item.off_red    <= it.off_red;
		mask_item.off_green  <= it.off_green;
		mask_item.off_blue   <= it.off_blue;
	endtask

	// Drop valid for the given number of cycles
	task automatic idle_for(input int cycles);
		mask_item.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Offer one item and hold it until the block takes it. Valid stays high on return so a
	// back-to-back item never lowers and raises it in the same step.
	task automatic send_item(input led_item_t it);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0)
				idle_for($urandom_range(1, 8));
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 40);
		end
		burst_left--;
		mask_item.valid <= 1'b1;
		load_item(it);
		do @(posedge clk); while (!mask_item.ready);
		sb.note_item(it);
	endtask

	// Hold off the sender until every expected drive item is back, then let the pipe empty out
	task automatic drain_pipe();
		mask_item.valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_drive.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register write: one cycle of cfg_we, mirrored at the edge that takes it; cfg_we then
	// drops before return so the next write raises cfg_we in a later step
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_setup(input fade_mode_t m, input logic [15:0] span,
			input logic [8:0] gain);
		write_reg(REG_FADE_MODE, 16'(m));
		write_reg(REG_FADE_TIME, span);
		write_reg(REG_BRIGHTNESS, 16'(gain));
	endtask

	// Random LED item shaped around the current fade time: most elapsed values fall inside
	// the transition or near the deep fade and done thresholds, some anywhere.
	function automatic led_item_t draw_led(input logic [15:0] span);
		led_item_t       it;
		logic [95:0]     raw;
		longint unsigned e;
		int unsigned     pick;
		raw = {$urandom, $urandom, $urandom};
		it  = raw[79:0];
		pick = $urandom_range(0, 9);
		case (pick)
			0: e = it.elapsed_ms;
			1: e = longint'(span) + $urandom_range(0, 3);
			2: e = (longint'(span) * $urandom_range(108, 148)) / 256 + $urandom_range(0, 2);
			3: e = (longint'(span) * $urandom_range(240, 256)) / 256 + $urandom_range(0, 2);
			default: e = $urandom_range(0, span);
		endcase
		if (e > 65535) e = 65535;
		it.elapsed_ms = e[15:0];
		// Favor the one-sided masks that deep fade shapes
		case ($urandom_range(0, 4))
			0: it.mask_from = 8'd0;
			1: it.mask_to = 8'd0;
			2: begin
				it.mask_from = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
				it.mask_to   = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
			end
			default: ;
		endcase
		if ($urandom_range(0, 7) == 0) {it.on_red, it.on_green, it.on_blue} = 24'hFFFFFF;
		if ($urandom_range(0, 7) == 0) {it.off_red, it.off_green, it.off_blue} = 24'h000000;
		return it;
	endfunction

	initial begin
		logic [15:0] span;
		logic [8:0]  gain;
		fade_mode_t  m;

		// Known values on every input before the first edge
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_FADE_MODE;
		cfg_data         <= '0;
		mask_item.valid  <= 1'b0;
		load_item('0);
		burst_left = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: linear crossfade over 250 ms at full brightness.
		// Start, midpoint, last step before done, first done step, far past the end.
		send_item(led_item_t'({16'd0, 8'd255, 8'd0, 24'hFFFFFF, 24'h000000}));
		send_item(led_item_t'({16'd125, 8'd255, 8'd0, 24'hFF8000, 24'h00FF7F}));
		send_item(led_item_t'({16'd248, 8'd0, 8'd255, 24'h123456, 24'hFEDCBA}));
		send_item(led_item_t'({16'd249, 8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF}));
		send_item(led_item_t'({16'd65535, 8'd0, 8'd255, 24'h000000, 24'hFFFFFF}));
		drain_pipe();

		// Deep fade over 1000 ms at half brightness: walk both edges of the dark window
		write_setup(FM_DEEP, 16'd1000, 9'd128);
		send_item(led_item_t'({16'd400, 8'd200, 8'd0, 24'hFFFFFF, 24'h102030}));
		send_item(led_item_t'({16'd450, 8'd255, 8'd0, 24'hFFFFFF, 24'h000000}));
		send_item(led_item_t'({16'd500, 8'd200, 8'd0, 24'hFFFFFF, 24'h405060}));
		send_item(led_item_t'({16'd500, 8'd0, 8'd200, 24'hFFFFFF, 24'h405060}));
		send_item(led_item_t'({16'd550, 8'd0, 8'd255, 24'hFFFFFF, 24'h000000}));
		send_item(led_item_t'({16'd551, 8'd0, 8'd255, 24'hFFFFFF, 24'h000000}));
		send_item(led_item_t'({16'd600, 8'd0, 8'd200, 24'hA0B0C0, 24'h0A0B0C}));
		send_item(led_item_t'({16'd300, 8'd100, 8'd50, 24'hFF00FF, 24'h00FF00}));
		drain_pipe();

		// Quadratic over the longest fade time, brightness above full scale
		write_setup(FM_QUAD, 16'hFFFF, 9'd300);
		send_item(led_item_t'({16'd32768, 8'd10, 8'd240, 24'hFFFFFF, 24'h000000}));
		send_item(led_item_t'({16'd65000, 8'd255, 8'd0, 24'hFFFFFF, 24'h808080}));
		send_item(led_item_t'({16'hFFFF, 8'd0, 8'd255, 24'hFFFFFF, 24'hFFFFFF}));
		drain_pipe();

		// Instant mode at zero brightness; the unused slot must leave everything alone
		write_setup(FM_INSTANT, 16'd250, 9'd0);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_item(led_item_t'({16'd0, 8'd255, 8'd0, 24'hFFFFFF, 24'hFFFFFF}));
		drain_pipe();

		// Zero fade time counts as done at once; maximum brightness code
		write_setup(FM_LINEAR, 16'd0, 9'd511);
		send_item(led_item_t'({16'd0, 8'd128, 8'd255, 24'hFFFFFF, 24'h000000}));
		send_item(led_item_t'({16'hFFFF, 8'd255, 8'd1, 24'h7F7F7F, 24'hFFFFFF}));
		drain_pipe();

		// Random phases, each with its own register setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			m = fade_mode_t'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0: span = 16'd0;
				1: span = 16'($urandom_range(1, 4));
				2: span = 16'hFFFF;
				3, 4: span = 16'($urandom_range(5, 300));
				5, 6: span = 16'($urandom_range(300, 5000));
				default: span = 16'($urandom_range(1, 65535));
			endcase
			case ($urandom_range(0, 9))
				0: gain = 9'd0;
				1: gain = 9'($urandom_range(257, 511));
				2, 3: gain = 9'($urandom_range(0, 256));
				default: gain = 9'd256;
			endcase
			write_setup(m, span, gain);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_item(draw_led(span));
				// Now and then let the pipeline run dry in the middle of a phase
				if ($urandom_range(0, 149) == 0)
					drain_pipe();
			end
			drain_pipe();
		end

		if (sb.fails == 0 && sb.expected_drive.size() == 0)
			$display("tb_led_mask_crossfade_blender_unit: clean");
		else
			$display("tb_led_mask_crossfade_blender_unit: errors");
		$finish;
	end

endmodule

### files.f
rtl/core/lmcb_pkg.sv
rtl/core/lmcb_if.sv
rtl/core/led_mask_crossfade_blender_unit.sv
rtl/core/lmcb_checker.sv
tb/sv/tb_led_mask_crossfade_blender_unit.sv
